@@ src/lcat_pkg.sv @@
// ----------------------------------------------------------------------------
// lcat_pkg
// Shared types and constants of the load cell reader: job record between the
// tick sequencer and the arithmetic back end, request and register codes.
// ----------------------------------------------------------------------------
package lcat_pkg;

	localparam int SUM_W   = 32;
	localparam int CNT_W   = 8;
	localparam int AVG_W   = 24;
	localparam int NET_W   = 25;
	localparam int COEF_W  = 48;
	localparam int ICPT_W  = 32;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 48;

	localparam logic [1:0] MODE_MEASURE = 2'd1;
	localparam logic [1:0] MODE_TARE    = 2'd2;

	localparam logic [1:0] KIND_PLAIN   = 2'd0;
	localparam logic [1:0] KIND_MEASURE = 2'd1;
	localparam logic [1:0] KIND_TARE    = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SCALE_COEFF  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_INTERCEPT    = 2'd2;

	localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT = 8'd20;
	localparam logic [COEF_W-1:0] RST_SCALE_COEFF  = 48'd10999844;
	localparam logic [ICPT_W-1:0] RST_INTERCEPT    = 32'd5556821;

	typedef struct packed {
		logic             sck;
		logic             busy;
		logic [1:0]       kind;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} job_t;

endpackage

@@ src/lcat_front.sv @@
// ----------------------------------------------------------------------------
// lcat_front
// Tick sequencer: drives the serial clock, shifts in conversion words, sums
// them and emits one job record per accepted tick.
// ----------------------------------------------------------------------------
module lcat_front #(
	parameter int DATA_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     dout_level,
	input  logic [1:0]               mode,
	input  logic [7:0]               sample_count,
	output lcat_pkg::job_t           job
);
	import lcat_pkg::*;

	localparam int BIDX_W = $clog2(DATA_BITS + 1);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_WAIT  = 3'd1;
	localparam logic [2:0] PH_HIGH  = 3'd2;
	localparam logic [2:0] PH_LOW   = 3'd3;
	localparam logic [2:0] PH_XHIGH = 3'd4;
	localparam logic [2:0] PH_XLOW  = 3'd5;

	logic [2:0]           phase_q, phase_d;
	logic [BIDX_W-1:0]    bidx_q, bidx_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [SUM_W-1:0]     sum_q, sum_d;
	logic [CNT_W-1:0]     reads_q, reads_d;
	logic                 tare_q, tare_d;
	logic                 sck_q, sck_d;
	logic [CNT_W-1:0]     n;
	logic [1:0]           kind;

	assign n = (sample_count == '0) ? CNT_W'(1) : sample_count;

	always_comb begin
		phase_d = phase_q;
		bidx_d  = bidx_q;
		shift_d = shift_q;
		sum_d   = sum_q;
		reads_d = reads_q;
		tare_d  = tare_q;
		sck_d   = sck_q;
		kind    = KIND_PLAIN;
		case (phase_q)
			PH_IDLE: begin
				if (mode == MODE_MEASURE || mode == MODE_TARE) begin
					tare_d  = (mode == MODE_TARE);
					sum_d   = '0;
					reads_d = '0;
					sck_d   = 1'b0;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (!dout_level) begin
					shift_d = '0;
					bidx_d  = '0;
					sck_d   = 1'b1;
					phase_d = PH_HIGH;
				end else begin
					sck_d = 1'b0;
				end
			end
			PH_HIGH: begin
				sck_d   = 1'b0;
				phase_d = PH_LOW;
			end
			PH_LOW: begin
				shift_d = {shift_q[DATA_BITS-2:0], dout_level};
				bidx_d  = bidx_q + BIDX_W'(1);
				sck_d   = 1'b1;
				phase_d = (bidx_d >= BIDX_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
			end
			PH_XHIGH: begin
				shift_d = shift_q ^ {1'b1, {(DATA_BITS-1){1'b0}}};
				sck_d   = 1'b0;
				phase_d = PH_XLOW;
			end
			PH_XLOW: begin
				sum_d   = sum_q + {{(SUM_W-DATA_BITS){1'b0}}, shift_q};
				reads_d = reads_q + CNT_W'(1);
				sck_d   = 1'b0;
				if (reads_d < n) begin
					phase_d = PH_WAIT;
				end else begin
					phase_d = PH_IDLE;
					kind    = tare_q ? KIND_TARE : KIND_MEASURE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				sck_d   = 1'b0;
			end
		endcase
	end

	always_comb begin
		job.sck   = sck_d;
		job.busy  = (phase_d != PH_IDLE);
		job.kind  = kind;
		job.sum   = sum_d;
		job.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bidx_q  <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			reads_q <= '0;
			tare_q  <= 1'b0;
			sck_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			shift_q <= shift_d;
			sum_q   <= sum_d;
			reads_q <= reads_d;
			tare_q  <= tare_d;
			sck_q   <= sck_d;
		end
	end

endmodule

@@ src/lcat_jobq.sv @@
// ----------------------------------------------------------------------------
// lcat_jobq
// Four-entry job queue between the tick sequencer and the arithmetic back end.
// ----------------------------------------------------------------------------
module lcat_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  lcat_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output lcat_pkg::job_t rd_job,
	output logic           avail
);
	import lcat_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   fill_q;

	assign full   = (fill_q == (PTR_W+1)'(DEPTH));
	assign avail  = (fill_q != '0);
	assign rd_job = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (rd && !wr) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

@@ src/lcat_back.sv @@
// ----------------------------------------------------------------------------
// lcat_back
// Arithmetic back end: bit-serial average divide, tare store, shared
// multiplier for the scaled weight, and the result register.
// ----------------------------------------------------------------------------
module lcat_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lcat_pkg::job_t                      job,
	input  logic                                job_avail,
	output logic                                job_take,
	input  logic signed [lcat_pkg::COEF_W-1:0]  scale_coeff,
	input  logic signed [lcat_pkg::ICPT_W-1:0]  weight_intercept,
	input  logic                                pop,
	output logic                                empty,
	output logic                                sck_level,
	output logic                                busy_res,
	output logic                                result_valid,
	output logic                                tare_done,
	output logic signed [lcat_pkg::NET_W-1:0]   net_count,
	output logic signed [31:0]                  weight
);
	import lcat_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam int HALF_W = COEF_W / 2;
	localparam int PROD_W = AVG_W + HALF_W;
	localparam int Q_W    = PROD_W + 1;
	localparam int W_W    = Q_W + 2;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV  = 3'd1;
	localparam logic [2:0] B_NET  = 3'd2;
	localparam logic [2:0] B_MLO  = 3'd3;
	localparam logic [2:0] B_MHI  = 3'd4;
	localparam logic [2:0] B_ADD  = 3'd5;
	localparam logic [2:0] B_OUT  = 3'd6;

	logic [2:0]              st_q;
	logic                    is_tare_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W:0]          rem_q;
	logic [SUM_W-1:0]        quo_q;
	logic [STEP_W-1:0]       step_q;
	logic [AVG_W-1:0]        tare_q;
	logic signed [NET_W-1:0] net_q;
	logic                    nneg_q;
	logic [AVG_W-1:0]        nmag_q;
	logic                    cneg_q;
	logic [COEF_W-1:0]       cmag_q;
	logic [PROD_W-1:0]       prod_q;
	logic [AVG_W:0]          round_q;
	logic signed [31:0]      w_q;
	logic                    out_valid_q;

	logic                    slot_free;
	logic [CNT_W:0]          rem_sh;
	logic                    ge;
	logic [AVG_W-1:0]        avg;
	logic signed [NET_W-1:0] net;
	logic [HALF_W-1:0]       mul_b;
	logic [PROD_W-1:0]       mul_p;
	logic [Q_W-1:0]          q;
	logic signed [W_W-1:0]   w_wide;
	logic signed [31:0]      w_sat;
	logic                    wr_plain;
	logic                    wr_done;

	assign slot_free = !out_valid_q || pop;
	assign empty     = !out_valid_q;

	assign rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, n_q});
	assign avg    = quo_q[AVG_W-1:0];
	assign net    = NET_W'({1'b0, avg}) - NET_W'({1'b0, tare_q});

	assign mul_b = (st_q == B_MLO) ? cmag_q[HALF_W-1:0] : cmag_q[COEF_W-1:HALF_W];
	assign mul_p = PROD_W'(nmag_q) * PROD_W'(mul_b);

	assign q      = {1'b0, prod_q} + Q_W'(round_q);
	assign w_wide = (cneg_q != nneg_q) ? W_W'(weight_intercept) + W_W'(q)
	                                   : W_W'(weight_intercept) - W_W'(q);

	always_comb begin
		if (w_wide > W_W'(32'sh7FFF_FFFF)) begin
			w_sat = 32'sh7FFF_FFFF;
		end else if (w_wide < -W_W'(33'sh0_8000_0000)) begin
			w_sat = 32'sh8000_0000;
		end else begin
			w_sat = w_wide[31:0];
		end
	end

	assign job_take = (st_q == B_IDLE) && job_avail && slot_free;
	assign wr_plain = job_take && (job.kind == KIND_PLAIN);
	assign wr_done  = (st_q == B_OUT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			step_q      <= '0;
			tare_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_plain || wr_done) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (job_take && job.kind != KIND_PLAIN) begin
						step_q <= '0;
						st_q   <= B_DIV;
					end
				end
				B_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						st_q <= B_NET;
					end
				end
				B_NET: begin
					if (is_tare_q) begin
						tare_q <= avg;
						st_q   <= B_OUT;
					end else begin
						st_q <= B_MLO;
					end
				end
				B_MLO: st_q <= B_MHI;
				B_MHI: st_q <= B_ADD;
				B_ADD: st_q <= B_OUT;
				B_OUT: begin
					if (slot_free) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (job_take) begin
					is_tare_q <= (job.kind == KIND_TARE);
					n_q       <= job.count;
					quo_q     <= job.sum;
					rem_q     <= '0;
				end
			end
			B_DIV: begin
				rem_q <= ge ? (rem_sh - {1'b0, n_q}) : rem_sh;
				quo_q <= {quo_q[SUM_W-2:0], ge};
			end
			B_NET: begin
				net_q  <= net;
				nneg_q <= net[NET_W-1];
				nmag_q <= net[NET_W-1] ? AVG_W'(-net) : AVG_W'(net);
				cneg_q <= scale_coeff[COEF_W-1];
				cmag_q <= scale_coeff[COEF_W-1] ? COEF_W'(-scale_coeff) : COEF_W'(scale_coeff);
			end
			B_MLO: begin
				prod_q <= mul_p;
			end
			B_MHI: begin
				round_q <= (AVG_W+1)'((PROD_W+1)'(prod_q) + (PROD_W+1)'(24'h80_0000) >> HALF_W);
				prod_q  <= mul_p;
			end
			B_ADD: begin
				w_q <= w_sat;
			end
			default: begin
			end
		endcase

		if (wr_plain) begin
			sck_level    <= job.sck;
			busy_res     <= job.busy;
			result_valid <= 1'b0;
			tare_done    <= 1'b0;
			net_count    <= '0;
			weight       <= '0;
		end else if (wr_done) begin
			sck_level    <= 1'b0;
			busy_res     <= 1'b0;
			result_valid <= !is_tare_q;
			tare_done    <= is_tare_q;
			net_count    <= is_tare_q ? '0 : net_q;
			weight       <= is_tare_q ? '0 : w_q;
		end
	end

endmodule

@@ src/load_cell_adc_reader_with_tare_top.sv @@
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare_top
// Load cell converter reader with averaging and tare: one result beat per
// accepted tick beat, configuration registers, sequencer, job queue, back end.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  ticks     push / full        dout_level, mode
//  results   pop / empty        sck_level, busy_res, result_valid, tare_done,
//                               net_count, weight
//  config    cfg_valid/ready    cfg_index, cfg_data
//
//  An ordinary tick goes from the queue straight into the result register.
//  A completion tick holds the back end for 32 divide steps of the average,
//  then net, then two passes of the shared 24x24 multiplier and add (measure).
//  Reset clears control state, tare offset and registers; no clearing pass.
//  A four-beat job queue lets tick beats enter while the back end stalls on
//  a full result register or on a completion.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare_top #(
	parameter int DATA_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                dout_level,
	input  logic [1:0]                          mode,
	output logic                                empty,
	input  logic                                pop,
	output logic                                sck_level,
	output logic                                busy_res,
	output logic                                result_valid,
	output logic                                tare_done,
	output logic signed [lcat_pkg::NET_W-1:0]   net_count,
	output logic signed [31:0]                  weight,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lcat_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [lcat_pkg::CDATA_W-1:0]        cfg_data
);
	import lcat_pkg::*;

	logic [CNT_W-1:0]         sample_count_q;
	logic signed [COEF_W-1:0] scale_coeff_q;
	logic signed [ICPT_W-1:0] intercept_q;
	logic                     accept;
	logic                     job_take;
	logic                     job_avail;
	job_t                     front_job;
	job_t                     head_job;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= RST_SAMPLE_COUNT;
			scale_coeff_q  <= RST_SCALE_COEFF;
			intercept_q    <= RST_INTERCEPT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[CNT_W-1:0];
				CFG_SCALE_COEFF:  scale_coeff_q  <= cfg_data[COEF_W-1:0];
				CFG_INTERCEPT:    intercept_q    <= cfg_data[ICPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lcat_front #(
		.DATA_BITS(DATA_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.dout_level   (dout_level),
		.mode         (mode),
		.sample_count (sample_count_q),
		.job          (front_job)
	);

	lcat_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (front_job),
		.full   (full),
		.rd     (job_take),
		.rd_job (head_job),
		.avail  (job_avail)
	);

	lcat_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job              (head_job),
		.job_avail        (job_avail),
		.job_take         (job_take),
		.scale_coeff      (scale_coeff_q),
		.weight_intercept (intercept_q),
		.pop              (pop),
		.empty            (empty),
		.sck_level        (sck_level),
		.busy_res         (busy_res),
		.result_valid     (result_valid),
		.tare_done        (tare_done),
		.net_count        (net_count),
		.weight           (weight)
	);

endmodule
